// File: hw/rtl/sis_pkg.sv
`default_nettype none

package sis_pkg;

    localparam int C_CAPACITY = 256;
    localparam int C_IDX_W    = $clog2(C_CAPACITY);
    localparam int C_CNT_W    = C_IDX_W + 1;
    localparam int C_VAL_W    = 8;
    localparam int C_POS_W    = 8;
    localparam int C_OP_W     = 3;

    typedef enum logic [C_OP_W-1:0] {
        OP_INSERT = 3'd0,
        OP_ERASE  = 3'd1,
        OP_QUERY  = 3'd2,
        OP_READ   = 3'd3,
        OP_CLEAR  = 3'd4
    } t_opcode;

    typedef struct packed {
        logic capture;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

// File: hw/rtl/sis_in_if.sv
`default_nettype none

interface sis_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] opcode;
    logic [7:0] value;
    logic [7:0] position;

    modport source (output valid, output opcode, output value, output position, input ready);
    modport sink (input valid, input opcode, input value, input position, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/sis_out_if.sv
`default_nettype none

interface sis_out_if;
    logic       valid;
    logic       ready;
    logic       success;
    logic [7:0] element;
    logic [8:0] count;
    logic       range_error;

    modport source (output valid, output success, output element, output count,
                    output range_error, input ready);
    modport sink (input valid, input success, input element, input count,
                  input range_error, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/sis_ctrl.sv
`default_nettype none

module sis_ctrl
    import sis_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_COMMIT
    } t_state;

    t_state r_state, n_state;

    assign o_in_ready     = (r_state == S_IDLE);
    assign o_cmd.capture  = i_in_valid && (r_state == S_IDLE);
    assign o_cmd.commit   = (r_state == S_COMMIT) && i_stat.out_free;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_READ;
            end
            S_READ: begin
                n_state = S_COMMIT;
            end
            S_COMMIT: begin
                if (i_stat.out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_commit_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |-> ($past(r_state) == S_READ || $past(r_state) == S_COMMIT))
        else $error("commit without a preceding table read");

    a_capture_leads_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> (r_state == S_READ))
        else $error("captured item did not start its table read");

    a_no_capture_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_cmd.capture)
        else $error("item captured while another is in flight");

endmodule

`default_nettype wire

// File: hw/rtl/sis_dp.sv
`default_nettype none

module sis_dp
    import sis_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_dp_cmd            i_cmd,
    output t_dp_stat                o_stat,
    input  wire logic [C_OP_W-1:0]  i_opcode,
    input  wire logic [C_VAL_W-1:0] i_value,
    input  wire logic [C_POS_W-1:0] i_position,
    input  wire logic               i_out_ready,
    output logic                    o_out_valid,
    output logic                    o_success,
    output logic [C_VAL_W-1:0]      o_element,
    output logic [C_CNT_W-1:0]      o_count,
    output logic                    o_range_error
);

    logic [C_OP_W-1:0]  r_op;
    logic [C_VAL_W-1:0] r_value;
    logic [C_POS_W-1:0] r_pos;

    logic [C_VAL_W-1:0] r_list_mem [C_CAPACITY];
    logic [C_IDX_W-1:0] r_slot_mem [C_CAPACITY];
    logic [C_VAL_W-1:0] r_list_rd;
    logic [C_IDX_W-1:0] r_slot_rd;

    logic [C_CAPACITY-1:0] r_flags;
    logic [C_CNT_W-1:0]    r_count, n_count;

    logic               r_out_valid;
    logic               r_success, n_success;
    logic [C_VAL_W-1:0] r_element, n_element;
    logic               r_rerr, n_rerr;

    logic [C_CNT_W-1:0] cnt_m1;
    logic               member;
    logic [C_IDX_W-1:0] list_raddr;
    logic               list_we, slot_we;
    logic [C_IDX_W-1:0] list_waddr, slot_waddr;
    logic [C_VAL_W-1:0] list_wdata;
    logic [C_IDX_W-1:0] slot_wdata;
    logic               flag_set, flag_clr, clear_all;

    assign cnt_m1     = r_count - C_CNT_W'(1);
    assign member     = r_flags[r_value[C_IDX_W-1:0]];
    assign list_raddr = (r_op == OP_ERASE) ? cnt_m1[C_IDX_W-1:0] : r_pos[C_IDX_W-1:0];

    always_comb begin
        n_count    = r_count;
        n_success  = 1'b0;
        n_element  = '0;
        n_rerr     = 1'b0;
        list_we    = 1'b0;
        slot_we    = 1'b0;
        list_waddr = r_count[C_IDX_W-1:0];
        list_wdata = r_value;
        slot_waddr = r_value[C_IDX_W-1:0];
        slot_wdata = r_count[C_IDX_W-1:0];
        flag_set   = 1'b0;
        flag_clr   = 1'b0;
        clear_all  = 1'b0;
        case (r_op)
            OP_INSERT: begin
                if (!member && (r_count < C_CNT_W'(C_CAPACITY))) begin
                    list_we   = 1'b1;
                    slot_we   = 1'b1;
                    flag_set  = 1'b1;
                    n_count   = r_count + C_CNT_W'(1);
                    n_success = 1'b1;
                end
            end
            OP_ERASE: begin
                // The last entry moves into the freed slot and its back-pointer follows.
                list_waddr = r_slot_rd;
                list_wdata = r_list_rd;
                slot_waddr = r_list_rd[C_IDX_W-1:0];
                slot_wdata = r_slot_rd;
                if (member && (r_count != '0) && ({1'b0, r_slot_rd} < r_count)) begin
                    list_we   = 1'b1;
                    slot_we   = 1'b1;
                    flag_clr  = 1'b1;
                    n_count   = cnt_m1;
                    n_success = 1'b1;
                end
            end
            OP_QUERY: begin
                n_success = member;
            end
            OP_READ: begin
                if ({1'b0, r_pos} < r_count) begin
                    n_element = r_list_rd;
                    n_success = 1'b1;
                end else begin
                    n_rerr = 1'b1;
                end
            end
            OP_CLEAR: begin
                clear_all = 1'b1;
                n_count   = '0;
                n_success = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op    <= i_opcode;
            r_value <= i_value;
            r_pos   <= i_position;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && list_we) begin
            r_list_mem[list_waddr] <= list_wdata;
        end
        r_list_rd <= r_list_mem[list_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && slot_we) begin
            r_slot_mem[slot_waddr] <= slot_wdata;
        end
        r_slot_rd <= r_slot_mem[r_value[C_IDX_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                r_count <= n_count;
                if (clear_all) begin
                    r_flags <= '0;
                end else if (flag_set) begin
                    r_flags[r_value[C_IDX_W-1:0]] <= 1'b1;
                end else if (flag_clr) begin
                    r_flags[r_value[C_IDX_W-1:0]] <= 1'b0;
                end
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_success <= n_success;
            r_element <= n_element;
            r_rerr    <= n_rerr;
        end
    end

    assign o_stat.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_success       = r_success;
    assign o_element       = r_element;
    assign o_count         = r_count;
    assign o_range_error   = r_rerr;

    a_flags_match_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_flags) == 32'(r_count))
        else $error("membership flags disagree with the member count");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= C_CNT_W'(C_CAPACITY))
        else $error("member count above capacity");

    a_result_from_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |=> r_out_valid)
        else $error("committed item produced no result");

endmodule

`default_nettype wire

// File: hw/rtl/sparse_index_set_core.sv
`default_nettype none

// Channel   Direction  Payload                                   Handshake
// i_in      sink       opcode[2:0] value[7:0] position[7:0]      valid/ready
// o_out     source     success element[7:0] count[8:0] range_err valid/ready
//
// Every item passes three steps: capture, one registered read of the member
// list and slot tables, then the commit of all table and flag updates.
// Reset clears the membership flags and the count; the tables themselves hold
// whatever they held. A stalled output holds the commit cycle, so a new item
// is taken only once the previous result has a place.

module sparse_index_set_core
    import sis_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    sis_in_if.sink     i_in,
    sis_out_if.source  o_out
);

    t_dp_cmd  cmd;
    t_dp_stat stat;
    logic     in_ready;

    assign i_in.ready = in_ready;

    sis_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    sis_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_opcode      (i_in.opcode),
        .i_value       (i_in.value),
        .i_position    (i_in.position),
        .i_out_ready   (o_out.ready),
        .o_out_valid   (o_out.valid),
        .o_success     (o_out.success),
        .o_element     (o_out.element),
        .o_count       (o_out.count),
        .o_range_error (o_out.range_error)
    );

endmodule

`default_nettype wire
